/* hdl/sacl_pkg.sv */
// Package for the set-associative cache unit: geometry constants, types and helpers.
// No dependencies.
package sacl_pkg;
   localparam int MaxSets    = 256;
   localparam int MaxWays    = 8;
   localparam int AddrBits   = 32;
   localparam int SetIdxBits = $clog2(MaxSets);
   localparam int WayIdxBits = $clog2(MaxWays);
   localparam int TagBits    = 32;
   localparam int AgeBits    = 3;
   localparam logic [AgeBits-1:0] AgeMax = 3'd7;
   localparam logic [3:0] OffsetMax = 4'd12;
   localparam logic [3:0] SetBitsMax = 4'(SetIdxBits);
   localparam logic [3:0] WaysMax = 4'(MaxWays);
   // line entry layout: valid, dirty, age, tag
   localparam int LineBits   = 2 + AgeBits + TagBits;
   localparam int RowBits    = LineBits * MaxWays;

   // register indexes
   localparam logic [1:0] RegOffsetBits = 2'd0;
   localparam logic [1:0] RegSetBits    = 2'd1;
   localparam logic [1:0] RegWaysInUse  = 2'd2;
   localparam logic [1:0] RegWriteBack  = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic                 dirty;
      logic [AgeBits-1:0]   age;
      logic [TagBits-1:0]   tag;
   } line_type;

   typedef line_type [MaxWays-1:0] row_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction
endpackage

/* hdl/sacl_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module sacl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hdl/set_assoc_cache_lru_wt_wb_unit.sv */
// Top level of the set-associative cache unit with true-LRU and write-through/back.
// Depends on sacl_pkg and sacl_ram.
//
// One request is taken when start is high and busy is low. The set row is read
// from a RAM with registered read, then lookup, victim choice and age update are
// done and the row is written back; the response then strobes on rsp_valid. Busy
// is high in the read and update states, so a new request waits for busy to
// fall. After reset a clearing pass of 256 rows (one row per cycle) runs with
// busy high; configuration writes are taken throughout.
module set_assoc_cache_lru_wt_wb_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_address,
   input  logic        req_is_write,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic        rsp_mem_read,
   output logic        rsp_mem_writes,
   output logic [2:0]  rsp_victim_way,
   output logic [31:0] rsp_total_reads,
   output logic [31:0] rsp_total_writes,
   output logic [31:0] rsp_total_hits,
   output logic [31:0] rsp_total_misses
);
   import sacl_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [SetIdxBits:0]   clr_ff, clr_in;
   logic [3:0] offset_bits_ff, set_bits_ff, ways_ff;
   logic       write_back_ff;
   logic [SetIdxBits-1:0] set_ff, set_in;
   logic [TagBits-1:0]    tag_ff, tag_in;
   logic                  wr_ff, wr_in;
   logic [31:0] reads_ff, writes_ff, hits_ff, misses_ff;
   logic        rsp_valid_ff, rsp_hit_ff, rsp_mread_ff, rsp_mwr_ff;
   logic [2:0]  rsp_way_ff;

   logic          ram_we;
   logic [SetIdxBits-1:0] ram_waddr, ram_raddr;
   row_type       row_rd, row_wr;

   sacl_ram #(.Width(RowBits), .Depth(MaxSets)) u_rows (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(row_wr),
      .rd_addr(ram_raddr),
      .rd_data(row_rd)
   );

   // address split with clamped geometry
   logic [3:0] ob, sb;
   logic [31:0] shifted;
   always_comb begin
      ob = (offset_bits_ff > OffsetMax) ? OffsetMax : offset_bits_ff;
      sb = (set_bits_ff > SetBitsMax) ? SetBitsMax : set_bits_ff;
      shifted = req_address >> ob;
      set_in = SetIdxBits'(shifted & ((32'd1 << sb) - 32'd1));
      tag_in = shifted >> sb;
      wr_in  = req_is_write;
   end

   // lookup, victim choice and row update
   logic [3:0] ways;
   logic       hit, found, mwr;
   logic [WayIdxBits-1:0] w;
   logic [AgeBits-1:0] old_age, best;
   always_comb begin
      ways = (ways_ff == 4'd0) ? 4'd1 : ((ways_ff > WaysMax) ? WaysMax : ways_ff);
      hit = 1'b0; found = 1'b0; w = '0; best = '0; mwr = 1'b0;
      for (int i = MaxWays - 1; i >= 0; i--) begin
         if (4'(i) < ways && row_rd[i].valid && row_rd[i].tag == tag_ff) begin
            hit = 1'b1; w = WayIdxBits'(i);
         end
      end
      if (!hit) begin
         for (int i = MaxWays - 1; i >= 0; i--) begin
            if (4'(i) < ways && !row_rd[i].valid) begin
               found = 1'b1; w = WayIdxBits'(i);
            end
         end
         if (!found) begin
            for (int i = 0; i < MaxWays; i++) begin
               if (4'(i) < ways && row_rd[i].age > best) begin
                  best = row_rd[i].age; w = WayIdxBits'(i);
               end
            end
         end
      end
      old_age = (!hit && found) ? AgeMax : row_rd[w].age;
      row_wr = row_rd;
      if (hit) begin
         if (wr_ff) begin
            if (write_back_ff) row_wr[w].dirty = 1'b1;
            else               mwr = 1'b1;
         end
      end else begin
         if (write_back_ff) begin
            mwr = row_rd[w].valid && row_rd[w].dirty;
            row_wr[w].dirty = wr_ff;
         end else begin
            mwr = wr_ff;
            row_wr[w].dirty = 1'b0;
         end
         row_wr[w].valid = 1'b1;
         row_wr[w].tag   = tag_ff;
      end
      for (int i = 0; i < MaxWays; i++) begin
         if (4'(i) < ways && WayIdxBits'(i) != w && row_rd[i].age < old_age
             && row_rd[i].age < AgeMax) begin
            row_wr[i].age = row_rd[i].age + 1'b1;
         end
      end
      row_wr[w].age = '0;
      if (state_ff == ST_CLEAR) row_wr = '0;
   end

   // RAM ports and sequencing
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = set_ff;
      ram_raddr = set_in;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff[SetIdxBits-1:0];
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == (SetIdxBits+1)'(MaxSets - 1)) state_in = ST_IDLE;
         end
         ST_IDLE:   if (start) state_in = ST_READ;
         ST_READ: begin
            // keep reading the held set, the request ports may already move on
            ram_raddr = set_ff;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         offset_bits_ff <= 4'd5; set_bits_ff <= 4'd0; ways_ff <= 4'd1;
         write_back_ff <= 1'b0;
         reads_ff <= '0; writes_ff <= '0; hits_ff <= '0; misses_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_we) begin
            case (csr_index)
               RegOffsetBits: offset_bits_ff <= csr_wdata;
               RegSetBits:    set_bits_ff    <= csr_wdata;
               RegWaysInUse:  ways_ff        <= csr_wdata;
               RegWriteBack:  write_back_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         rsp_valid_ff <= (state_ff == ST_UPDATE);
         if (state_ff == ST_UPDATE) begin
            if (hit) hits_ff <= sat_inc(hits_ff);
            else begin
               misses_ff <= sat_inc(misses_ff);
               reads_ff  <= sat_inc(reads_ff);
            end
            if (mwr) writes_ff <= sat_inc(writes_ff);
         end
      end
   end

   // hold request and response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         set_ff <= set_in; tag_ff <= tag_in; wr_ff <= wr_in;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_hit_ff <= hit; rsp_mread_ff <= !hit; rsp_mwr_ff <= mwr;
         rsp_way_ff <= 3'(w);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_mem_read     = rsp_mread_ff;
   assign rsp_mem_writes   = rsp_mwr_ff;
   assign rsp_victim_way   = rsp_way_ff;
   assign rsp_total_reads  = reads_ff;
   assign rsp_total_writes = writes_ff;
   assign rsp_total_hits   = hits_ff;
   assign rsp_total_misses = misses_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> rsp_valid) else $error("missing response");
   a_read_follows_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_READ))
      else $error("request not taken");
   a_miss_reads: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit != rsp_mem_read)) else $error("hit and fetch disagree");
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_UPDATE || state_ff == ST_CLEAR))
      else $error("stray RAM write");
endmodule
